@@ design/fpsl_pkg.sv @@
// fpsl_pkg: types, twiddle table and saturation helpers for the FFT phase shift line.
// No dependencies.

package fpsl_pkg;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_FILL,
      ST_RD_A,
      ST_RD_B,
      ST_MUL,
      ST_ADD,
      ST_WR_A,
      ST_WR_B,
      ST_PH_RD,
      ST_PH_WR,
      ST_OUT_RD,
      ST_OUT_WAIT,
      ST_OUT_SEND
   } state_type;

   typedef enum logic [1:0] {
      MODE_FWD,
      MODE_PH,
      MODE_INV
   } mode_type;

   localparam int DATA_W = 24;
   localparam int SMP_W  = 16;
   localparam int TW_W   = 5;

   // cos(2 pi k / 64), Q1.15, k = 0..16
   function automatic logic signed [15:0] cos_q15(input logic [4:0] k);
      logic signed [15:0] c;
      case (k)
         5'd0:    c = 16'sd32767;
         5'd1:    c = 16'sd32610;
         5'd2:    c = 16'sd32138;
         5'd3:    c = 16'sd31357;
         5'd4:    c = 16'sd30274;
         5'd5:    c = 16'sd28899;
         5'd6:    c = 16'sd27246;
         5'd7:    c = 16'sd25330;
         5'd8:    c = 16'sd23170;
         5'd9:    c = 16'sd20788;
         5'd10:   c = 16'sd18205;
         5'd11:   c = 16'sd15447;
         5'd12:   c = 16'sd12540;
         5'd13:   c = 16'sd9512;
         5'd14:   c = 16'sd6393;
         5'd15:   c = 16'sd3212;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [15:0] tw_cos(input logic [TW_W-1:0] k);
      logic signed [15:0] c;
      if (k <= 5'd16) begin
         c = cos_q15(k);
      end else begin
         c = -cos_q15(5'd0 - k);
      end
      return c;
   endfunction

   function automatic logic signed [15:0] tw_sin(input logic [TW_W-1:0] k);
      logic signed [15:0] c;
      if (k <= 5'd16) begin
         c = cos_q15(5'd16 - k);
      end else begin
         c = cos_q15(k - 5'd16);
      end
      return c;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
      logic signed [23:0] r;
      if (v > 27'sd8388607) begin
         r = 24'sd8388607;
      end else if (v < -27'sd8388608) begin
         r = -24'sd8388608;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > 24'sd32767) begin
         r = 16'sd32767;
      end else if (v < -24'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

@@ design/fpsl_ram.sv @@
// fpsl_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module fpsl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fft_phase_shift_line.sv @@
// fft_phase_shift_line: top level, sequencer and shared complex multiplier.
// Depends on fpsl_pkg and fpsl_ram.
//
// Takes one line of up to LINE_LEN real samples, zero-padded when req_tlast ends it early
// (one item per cycle while loading; the first LINE_LEN/2+1 items also carry the mode
// phases), runs a forward radix-2 FFT, applies the phases, conjugates and bit-reverses,
// runs the FFT again with halving per stage and returns LINE_LEN results, the last with
// rsp_tlast. req_tready is low from the end of the line until the last result is taken.
// One complex multiplier and one spectrum RAM port pair serve every pass: each butterfly
// steps through RD_A, RD_B, MUL, ADD, WR_A and WR_B, each phase product through PH_RD,
// MUL, ADD and PH_WR, and each result through OUT_RD, OUT_WAIT and OUT_SEND, where it
// waits while rsp_tready is low.

module fft_phase_shift_line
   import fpsl_pkg::*;
#(
   parameter int LINE_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // sample[15:0], phase_re[31:16], phase_im[47:32]
   input  logic        req_tlast,   // last_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // shifted_sample[15:0]
   output logic        rsp_tlast    // last_out
);

   localparam int LG     = $clog2(LINE_LEN);
   localparam int STG_W  = $clog2(LG);
   localparam int HALF   = LINE_LEN / 2;
   localparam int NMODES = HALF + 1;
   localparam int PH_AW  = $clog2(NMODES);
   localparam int SA_W   = LG + 1;

   function automatic logic [LG-1:0] rev_idx(input logic [LG-1:0] x);
      logic [LG-1:0] r;
      for (int i = 0; i < LG; i++) begin
         r[i] = x[LG-1-i];
      end
      return r;
   endfunction

   // butterfly output: a +/- t, optionally halved, saturated
   function automatic logic signed [23:0] bf_out(input logic signed [23:0] a,
                                                 input logic signed [23:0] t,
                                                 input logic sub,
                                                 input logic halve);
      logic signed [26:0] v;
      v = sub ? (27'(a) - 27'(t)) : (27'(a) + 27'(t));
      if (halve) begin
         v = (v + 27'sd1) >>> 1;
      end
      return sat24(v);
   endfunction

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [LG-1:0]    idx_ff, idx_in;
   logic [STG_W-1:0] stage_ff, stage_in;
   logic signed [23:0] a_re_ff, a_re_in, a_im_ff, a_im_in;
   logic signed [23:0] t_re_ff, t_re_in, t_im_ff, t_im_in;
   logic signed [40:0] p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in, p4_ff, p4_in;
   logic signed [15:0] out_ff, out_in;

   logic            spec_we;
   logic [SA_W-1:0] spec_waddr, spec_raddr;
   logic [47:0]     spec_wdata, spec_rdata;
   logic            ph_we;
   logic [PH_AW-1:0] ph_waddr, ph_raddr;
   logic [31:0]     ph_wdata, ph_rdata;

   fpsl_ram #(.WIDTH(48), .DEPTH(2 * LINE_LEN)) u_spec_ram (
      .clock   (clock),
      .wr_en   (spec_we),
      .wr_addr (spec_waddr),
      .wr_data (spec_wdata),
      .rd_addr (spec_raddr),
      .rd_data (spec_rdata)
   );

   fpsl_ram #(.WIDTH(32), .DEPTH(NMODES)) u_phase_ram (
      .clock   (clock),
      .wr_en   (ph_we),
      .wr_addr (ph_waddr),
      .wr_data (ph_wdata),
      .rd_addr (ph_raddr),
      .rd_data (ph_rdata)
   );

   logic [LG:0]     kx, hmask, top_w;
   logic [LG-1:0]   top, bot, jj, ph_mir;
   logic [10:0]     tiw;
   logic [TW_W-1:0] ti;
   logic            bank, halve, is_last_idx, is_half_end, is_stage_end, in_modes;
   logic signed [16:0] w_re, w_im;
   logic signed [23:0] x_re, x_im;
   logic signed [41:0] s_re, s_im;
   logic signed [23:0] ni;

   always_comb begin
      kx     = {1'b0, idx_ff};
      hmask  = ((SA_W)'(1) << stage_ff) - (SA_W)'(1);
      top_w  = (((kx >> stage_ff) << stage_ff) << 1) | (kx & hmask);
      top    = top_w[LG-1:0];
      bot    = top | (LG'(1) << stage_ff);
      jj     = idx_ff & hmask[LG-1:0];
      ph_mir = LG'(0) - idx_ff;
      tiw    = 11'(jj) << (3'(TW_W) - 3'(stage_ff));
      ti     = tiw[TW_W-1:0];
      bank   = (mode_ff == MODE_INV);
      halve  = (mode_ff == MODE_INV);
      is_last_idx  = (idx_ff == LG'(LINE_LEN - 1));
      is_half_end  = (idx_ff == LG'(HALF - 1));
      is_stage_end = (stage_ff == STG_W'(LG - 1));
      in_modes     = ({1'b0, idx_ff} < (LG + 1)'(NMODES));

      x_re = spec_rdata[23:0];
      x_im = spec_rdata[47:24];
      if (mode_ff == MODE_PH) begin
         w_re = 17'(signed'(ph_rdata[15:0]));
         w_im = ({1'b0, idx_ff} > (LG + 1)'(HALF)) ? -17'(signed'(ph_rdata[31:16]))
                                                    : 17'(signed'(ph_rdata[31:16]));
      end else begin
         w_re = 17'(tw_cos(ti));
         w_im = -17'(tw_sin(ti));
      end
      s_re = (42'(p1_ff) - 42'(p2_ff) + 42'sd16384) >>> 15;
      s_im = (42'(p3_ff) + 42'(p4_ff) + 42'sd16384) >>> 15;
      ni   = t_im_ff;

      state_in = state_ff;
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      stage_in = stage_ff;
      a_re_in  = a_re_ff;
      a_im_in  = a_im_ff;
      t_re_in  = t_re_ff;
      t_im_in  = t_im_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      p3_in    = p3_ff;
      p4_in    = p4_ff;
      out_in   = out_ff;

      spec_we    = 1'b0;
      spec_waddr = {1'b0, rev_idx(idx_ff)};
      spec_wdata = '0;
      spec_raddr = {bank, top};
      ph_we      = 1'b0;
      ph_waddr   = idx_ff[PH_AW-1:0];
      ph_wdata   = '0;
      ph_raddr   = ({1'b0, idx_ff} <= (LG + 1)'(HALF)) ? idx_ff[PH_AW-1:0]
                                                      : ph_mir[PH_AW-1:0];
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               spec_we    = 1'b1;
               spec_wdata = {24'd0, 24'(signed'(req_tdata[15:0]))};
               ph_we      = in_modes;
               ph_wdata   = req_tdata[47:16];
               if (is_last_idx) begin
                  idx_in   = '0;
                  stage_in = '0;
                  mode_in  = MODE_FWD;
                  state_in = ST_RD_A;
               end else begin
                  idx_in = idx_ff + LG'(1);
                  if (req_tlast) begin
                     state_in = ST_FILL;
                  end
               end
            end
         end
         ST_FILL: begin
            spec_we = 1'b1;
            ph_we   = in_modes;
            if (is_last_idx) begin
               idx_in   = '0;
               stage_in = '0;
               mode_in  = MODE_FWD;
               state_in = ST_RD_A;
            end else begin
               idx_in = idx_ff + LG'(1);
            end
         end
         ST_RD_A: begin
            spec_raddr = {bank, top};
            state_in   = ST_RD_B;
         end
         ST_RD_B: begin
            spec_raddr = {bank, bot};
            a_re_in    = x_re;
            a_im_in    = x_im;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            p1_in    = w_re * x_re;
            p2_in    = w_im * x_im;
            p3_in    = w_re * x_im;
            p4_in    = w_im * x_re;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            t_re_in  = sat24(s_re[26:0]);
            t_im_in  = sat24(s_im[26:0]);
            state_in = (mode_ff == MODE_PH) ? ST_PH_WR : ST_WR_A;
         end
         ST_WR_A: begin
            spec_we    = 1'b1;
            spec_waddr = {bank, top};
            spec_wdata = {bf_out(a_im_ff, t_im_ff, 1'b0, halve),
                          bf_out(a_re_ff, t_re_ff, 1'b0, halve)};
            state_in   = ST_WR_B;
         end
         ST_WR_B: begin
            spec_we    = 1'b1;
            spec_waddr = {bank, bot};
            spec_wdata = {bf_out(a_im_ff, t_im_ff, 1'b1, halve),
                          bf_out(a_re_ff, t_re_ff, 1'b1, halve)};
            state_in   = ST_RD_A;
            if (is_half_end) begin
               idx_in = '0;
               if (is_stage_end) begin
                  stage_in = '0;
                  if (mode_ff == MODE_FWD) begin
                     mode_in  = MODE_PH;
                     state_in = ST_PH_RD;
                  end else begin
                     state_in = ST_OUT_RD;
                  end
               end else begin
                  stage_in = stage_ff + STG_W'(1);
               end
            end else begin
               idx_in = idx_ff + LG'(1);
            end
         end
         ST_PH_RD: begin
            spec_raddr = {1'b0, idx_ff};
            state_in   = ST_MUL;
         end
         ST_PH_WR: begin
            spec_we    = 1'b1;
            spec_waddr = {1'b1, rev_idx(idx_ff)};
            spec_wdata = {sat24(-27'(ni)), t_re_ff};
            if (is_last_idx) begin
               idx_in   = '0;
               stage_in = '0;
               mode_in  = MODE_INV;
               state_in = ST_RD_A;
            end else begin
               idx_in   = idx_ff + LG'(1);
               state_in = ST_PH_RD;
            end
         end
         ST_OUT_RD: begin
            spec_raddr = {1'b1, idx_ff};
            state_in   = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            out_in   = sat16(x_re);
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (is_last_idx) begin
                  idx_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  idx_in   = idx_ff + LG'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         mode_ff  <= MODE_FWD;
         idx_ff   <= '0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         idx_ff   <= idx_in;
         stage_ff <= stage_in;
      end
      a_re_ff <= a_re_in;
      a_im_ff <= a_im_in;
      t_re_ff <= t_re_in;
      t_im_ff <= t_im_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      p3_ff   <= p3_in;
      p4_ff   <= p4_in;
      out_ff  <= out_in;
   end

   assign rsp_tdata = out_ff;
   assign rsp_tlast = (state_ff == ST_OUT_SEND) && is_last_idx;

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("result offered while loading");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("no return to loading after last result");

   a_bf_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_A) |-> !idx_ff[LG-1])
      else $error("butterfly index out of range");

   a_no_write_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_SEND || state_ff == ST_OUT_RD) |-> !spec_we)
      else $error("spectrum written during output");
`endif

endmodule

@@ tb/fft_phase_shift_line_tb.sv @@
// fft_phase_shift_line_tb: self-checking bench for the FFT phase shift line.
// Depends on fpsl_pkg and the fft_phase_shift_line RTL; a bit-true line predictor
// is built in and every result item is compared against it.

module fft_phase_shift_line_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEN    = 64;
   localparam int LG     = 6;
   localparam int NMODES = LEN / 2 + 1;

   typedef struct {
      logic [15:0] smp;
      bit          lst;
   } shift_res_t;

   typedef struct {
      logic [15:0] smp;
      logic [15:0] pre;
      logic [15:0] pim;
      bit          lst;
      bit          zero_line;
   } stim_row_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // sample[15:0], phase_re[31:16], phase_im[47:32]
   logic        req_tlast;   // last_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // shifted_sample[15:0]
   logic        rsp_tlast;   // last_out

   fft_phase_shift_line #(.LINE_LEN(LEN)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // predictor state
   longint     spec_re [LEN];
   longint     spec_im [LEN];
   longint     ph_re [NMODES];
   longint     ph_im [NMODES];
   int         loaded;
   shift_res_t shifted_q[$];

   int  errors;
   int  mismatches;
   int  items_in;
   int  items_out;
   int  lines_done;
   int  tx_idle_pct;
   int  rx_stall_pct;
   int  rx_hold;
   bit  zero_line_flag;

   localparam int COS_TAB [17] = '{32767, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
      23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

   function automatic longint clip(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic longint rnd_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint w_cos(int k);
      k = k & 31;
      return k <= 16 ? COS_TAB[k] : -COS_TAB[32 - k];
   endfunction

   function automatic longint w_sin(int k);
      k = k & 31;
      return k <= 16 ? COS_TAB[16 - k] : COS_TAB[k - 16];
   endfunction

   function automatic int bitrev(int x);
      int r;
      r = 0;
      for (int i = 0; i < LG; i++) begin
         r = (r << 1) | ((x >> i) & 1);
      end
      return r;
   endfunction

   task automatic radix2_pass(bit halve);
      int     m, h, j, top, bot, ti;
      longint wr, wi, tr, tim, v0r, v0i, v1r, v1i;
      for (int s = 0; s < LG; s++) begin
         m = 2 << s;
         h = m >> 1;
         for (int k = 0; k < LEN / 2; k++) begin
            j   = k % h;
            top = (k / h) * m + j;
            bot = top + h;
            ti  = (j * 64) / m;
            wr  = w_cos(ti);
            wi  = -w_sin(ti);
            tr  = clip(rnd_shr(wr * spec_re[bot] - wi * spec_im[bot], 15), 24);
            tim = clip(rnd_shr(wr * spec_im[bot] + wi * spec_re[bot], 15), 24);
            v0r = spec_re[top] + tr;
            v0i = spec_im[top] + tim;
            v1r = spec_re[top] - tr;
            v1i = spec_im[top] - tim;
            if (halve) begin
               v0r = rnd_shr(v0r, 1);
               v0i = rnd_shr(v0i, 1);
               v1r = rnd_shr(v1r, 1);
               v1i = rnd_shr(v1i, 1);
            end
            spec_re[top] = clip(v0r, 24);
            spec_im[top] = clip(v0i, 24);
            spec_re[bot] = clip(v1r, 24);
            spec_im[bot] = clip(v1i, 24);
         end
      end
   endtask

   task automatic clear_line();
      for (int k = 0; k < LEN; k++) begin
         spec_re[k] = 0;
         spec_im[k] = 0;
      end
      for (int k = 0; k < NMODES; k++) begin
         ph_re[k] = 0;
         ph_im[k] = 0;
      end
      loaded = 0;
   endtask

   // takes one accepted item, queues LEN results when it closes a line
   task automatic shift_line_item(logic [47:0] d, bit lst);
      longint     tre [LEN];
      longint     tim [LEN];
      longint     pr, pi, nr, ni;
      shift_res_t r;
      spec_re[bitrev(loaded)] = longint'($signed(d[15:0]));
      spec_im[bitrev(loaded)] = 0;
      if (loaded < NMODES) begin
         ph_re[loaded] = longint'($signed(d[31:16]));
         ph_im[loaded] = longint'($signed(d[47:32]));
      end
      loaded++;
      if (!lst && loaded < LEN) return;
      radix2_pass(0);
      for (int k = 0; k < LEN; k++) begin
         if (k < NMODES) begin
            pr = ph_re[k];
            pi = ph_im[k];
         end else begin
            pr = ph_re[LEN - k];
            pi = -ph_im[LEN - k];
         end
         nr = clip(rnd_shr(spec_re[k] * pr - spec_im[k] * pi, 15), 24);
         ni = clip(rnd_shr(spec_re[k] * pi + spec_im[k] * pr, 15), 24);
         tre[k] = nr;
         tim[k] = clip(-ni, 24);
      end
      for (int k = 0; k < LEN; k++) begin
         spec_re[bitrev(k)] = tre[k];
         spec_im[bitrev(k)] = tim[k];
      end
      radix2_pass(1);
      for (int k = 0; k < LEN; k++) begin
         r.smp = zero_line_flag ? 16'h0000 : 16'(clip(spec_re[k], 16));
         r.lst = (k == LEN - 1);
         shifted_q.push_back(r);
      end
      lines_done++;
      clear_line();
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("timeout with %0d results outstanding", shifted_q.size());
      $display("fft_phase_shift_line verification failed");
      $finish;
   end

   // input side monitor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         items_in++;
         shift_line_item(req_tdata, req_tlast);
      end
   end

   // result side: stall pattern and checker
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      shift_res_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         items_out++;
         if (shifted_q.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result item %h last %b", rsp_tdata, rsp_tlast);
            end
         end else begin
            e = shifted_q.pop_front();
            if (rsp_tdata !== e.smp || rsp_tlast !== e.lst) begin
               errors++;
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d: sample exp %h got %h, last exp %b got %b",
                           items_out, e.smp, rsp_tdata, e.lst, rsp_tlast);
               end
            end
         end
      end
   end

   task automatic send_item(logic [15:0] smp, logic [15:0] pre, logic [15:0] pim, bit lst);
      bit ok;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pim, pre, smp};
      req_tlast  <= lst;
      do begin
         @(negedge clock);
         ok = req_tready;
         @(posedge clock);
      end while (!ok);
   endtask

   function automatic logic [15:0] rnd_word();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_line();
      int n;
      bit end_flag;
      case ($urandom_range(9))
         0, 1:    n = $urandom_range(13, 40);
         2:       n = LEN;
         default: n = $urandom_range(1, 12);
      endcase
      end_flag = (n < LEN) ? 1'b1 : bit'($urandom_range(1));
      for (int i = 0; i < n; i++) begin
         send_item(rnd_word(), rnd_word(), rnd_word(), (i == n - 1) && end_flag);
      end
   endtask

   stim_row_t dir_tab [] = '{
      // one-sample line at full scale, unit phase
      '{16'h7FFF, 16'h7FFF, 16'h0000, 1'b1, 1'b0},
      // zero samples give zero output whatever the phase
      '{16'h0000, 16'h8000, 16'h8000, 1'b0, 1'b1},
      '{16'h0000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1},
      // negative and positive full scale, extreme phases
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0},
      '{16'h8000, 16'h8000, 16'h7FFF, 1'b0, 1'b0},
      '{16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0},
      '{16'h8000, 16'h0000, 16'h7FFF, 1'b1, 1'b0},
      // mixed values
      '{16'h1234, 16'h5A82, 16'hA57E, 1'b0, 1'b0},
      '{16'hFFFF, 16'h7FFF, 16'h0000, 1'b0, 1'b0},
      '{16'h0001, 16'h0000, 16'hFFFF, 1'b0, 1'b0},
      '{16'hEDCB, 16'hC000, 16'h4000, 1'b1, 1'b0}
   };

   initial begin
      int base;
      errors = 0;
      mismatches = 0;
      items_in = 0;
      items_out = 0;
      lines_done = 0;
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      rx_hold = 0;
      zero_line_flag = 1'b0;
      clear_line();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         zero_line_flag <= dir_tab[i].zero_line;
         send_item(dir_tab[i].smp, dir_tab[i].pre, dir_tab[i].pim, dir_tab[i].lst);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      zero_line_flag <= 1'b0;
      wait (shifted_q.size() == 0);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 50; rx_hold = 4000; end
            default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
         endcase
         base = items_in;
         while (items_in - base < 57) begin
            send_random_line();
         end
         req_tvalid <= 1'b0;
         @(posedge clock);
         wait (shifted_q.size() == 0);
      end

      repeat (3000) @(posedge clock);
      $display("%0d items in, %0d lines shifted, %0d results checked over four idle patterns",
               items_in, lines_done, items_out);
      if (errors == 0 && shifted_q.size() == 0) begin
         $display("fft_phase_shift_line verification clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("fft_phase_shift_line verification failed");
      end
      $finish;
   end

endmodule
